>>> design/assert_macros.svh
// Assertion macros shared by the timer bank modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared types and codes of the timer bank.
// ----------------------------------------------------------------------------
package otb_pkg;
  localparam int NUM_TIMERS_DEF = 16;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_ID   = 4'd1;
  localparam logic [3:0] ST_INACTIVE = 4'd2;
  localparam logic [3:0] ST_BAD_MODE = 4'd3;
  localparam logic [3:0] ST_BAD_DLY  = 4'd4;
  localparam logic [3:0] ST_BAD_PER  = 4'd5;
  localparam logic [3:0] ST_NO_FREE  = 4'd6;
  localparam logic [3:0] ST_STOPPED_ALREADY = 4'd7;
  localparam logic [3:0] ST_NO_CB    = 4'd8;

  localparam logic [1:0] SS_UNUSED  = 2'd0;
  localparam logic [1:0] SS_STOPPED = 2'd1;
  localparam logic [1:0] SS_RUNNING = 2'd2;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot_id;
    logic [1:0]  slot_state;
    logic [31:0] remaining_ticks;
    logic        fired;
    logic [15:0] fire_tag;
    logic        last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch input word
    logic cmd;       // execute command on latched word
    logic scan;      // evaluate scan slot, emit if due
    logic scan_next; // advance scan index
    logic tick_done; // increment tick count
    logic emit_idle; // emit empty tick result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_hit;
    logic scan_end;
    logic res_busy;
  } sts_t;
endpackage

>>> design/one_shot_periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_bank
// Pool of one-shot and periodic timers with a free-slot stack.
// ----------------------------------------------------------------------------
// One word in at a time. A command goes through load, execute and a return
// to idle. A tick scans every slot, one per cycle while no result waits, and
// emits one result per expiring slot (or one empty result); out_stall holds
// the scan while a result waits.
module one_shot_periodic_timer_bank
  import otb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_timer_id,
  input  logic [1:0]  in_timer_mode,
  input  logic [31:0] in_delay_ticks,
  input  logic [31:0] in_period_ticks,
  input  logic        in_has_callback,
  input  logic [15:0] in_callback_tag,
  input  logic [1:0]  in_stop_option,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [3:0]  out_slot_id,
  output logic [1:0]  out_slot_state,
  output logic [31:0] out_remaining_ticks,
  output logic        out_fired,
  output logic [15:0] out_fire_tag,
  output logic        out_last
);
  cmd_t cmd;
  sts_t sts;
  res_t res;

  otb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  otb_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_timer_id(in_timer_id), .in_timer_mode(in_timer_mode),
    .in_delay_ticks(in_delay_ticks), .in_period_ticks(in_period_ticks),
    .in_has_callback(in_has_callback), .in_callback_tag(in_callback_tag),
    .in_stop_option(in_stop_option),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign out_status          = res.status;
  assign out_slot_id         = res.slot_id;
  assign out_slot_state      = res.slot_state;
  assign out_remaining_ticks = res.remaining_ticks;
  assign out_fired           = res.fired;
  assign out_fire_tag        = res.fire_tag;
  assign out_last            = res.last;
endmodule

>>> design/otb_ctrl.sv
// ----------------------------------------------------------------------------
// otb_ctrl
// Sequencer: accepts a word, runs a command or a slot scan for a tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module otb_ctrl
  import otb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   hit_r, hit_nxt;

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (sts.is_tick) begin
          hit_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end else if (!sts.res_busy) begin
          cmd.cmd   = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_SCAN: begin
        if (!sts.res_busy) begin
          if (sts.scan_hit) begin
            cmd.scan = 1'b1;
            hit_nxt  = 1'b1;
          end
          if (sts.scan_end) begin
            cmd.tick_done = 1'b1;
            if (!hit_r && !sts.scan_hit) cmd.emit_idle = 1'b1;
            state_nxt = S_WAIT;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
    end
  end

  `ASSERT_CLK(a_stall_busy, clk, rst_n, (state_r != S_IDLE) |-> in_stall)
  `ASSERT_NEVER(a_cmd_scan, clk, rst_n, cmd.cmd && cmd.scan)
  `ASSERT_CLK(a_load_goes, clk, rst_n, cmd.load |=> (state_r == S_CMD))
endmodule

>>> design/otb_dp.sv
// ----------------------------------------------------------------------------
// otb_dp
// Slot storage, free stack, tick counter and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module otb_dp
  import otb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_timer_id,
  input  logic [1:0]  in_timer_mode,
  input  logic [31:0] in_delay_ticks,
  input  logic [31:0] in_period_ticks,
  input  logic        in_has_callback,
  input  logic [15:0] in_callback_tag,
  input  logic [1:0]  in_stop_option,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        res
);
  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  logic [2:0]  op_r;
  logic [7:0]  id_r;
  logic [1:0]  mode_r;
  logic [31:0] dly_r, per_r;
  logic        cb_r;
  logic [15:0] tag_r;
  logic [1:0]  opt_r;

  logic [1:0]  stat_r   [NUM_TIMERS];
  logic        peri_r   [NUM_TIMERS];
  logic [31:0] sdly_r   [NUM_TIMERS];
  logic [31:0] sper_r   [NUM_TIMERS];
  logic [31:0] match_r  [NUM_TIMERS];
  logic        hcb_r    [NUM_TIMERS];
  logic [15:0] stag_r   [NUM_TIMERS];
  logic [IW-1:0] fstk_r [NUM_TIMERS];
  logic [CW-1:0] fcnt_r;
  logic [31:0] tick_r;
  logic [IW-1:0] scan_r;
  logic        ov_r;
  res_t        res_r;

  logic [IW-1:0] sid;
  logic          id_ok;
  assign id_ok = ({24'd0, id_r} < 32'(NUM_TIMERS));
  assign sid   = id_r[IW-1:0];

  // due slots; a later due slot keeps the current word from being the last
  logic [NUM_TIMERS-1:0] hit_vec;
  logic                  later_hit;
  always_comb begin
    later_hit = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      hit_vec[i] = (stat_r[i] == SS_RUNNING) && (match_r[i] == tick_r);
      if ((i > int'(scan_r)) && hit_vec[i]) later_hit = 1'b1;
    end
  end

  logic scan_hit;
  assign scan_hit = hit_vec[scan_r];

  assign sts.is_tick  = (op_r == OP_TICK);
  assign sts.scan_hit = scan_hit;
  assign sts.scan_end = (32'(scan_r) == 32'(NUM_TIMERS - 1));
  assign sts.res_busy = ov_r && out_stall;

  // command decode
  res_t        r;
  logic        do_create, do_release, do_start, do_stop;
  logic [IW-1:0] rel_slot, new_slot;
  always_comb begin
    r = '0;
    r.last = 1'b1;
    do_create = 1'b0;
    do_release = 1'b0;
    do_start = 1'b0;
    do_stop = 1'b0;
    rel_slot = sid;
    new_slot = fstk_r[IW'(fcnt_r - CW'(1))];
    if (cmd.scan) begin
      r.slot_id = 4'(scan_r);
      r.fired   = hcb_r[scan_r];
      r.fire_tag = hcb_r[scan_r] ? stag_r[scan_r] : 16'd0;
      r.last    = !later_hit;
      if (peri_r[scan_r]) r.slot_state = SS_RUNNING;
      else begin
        r.slot_state = SS_UNUSED;
        do_release = 1'b1;
        rel_slot = scan_r;
      end
    end else if (cmd.emit_idle) begin
      r.last = 1'b1;
    end else if (op_r == OP_CREATE) begin
      if (fcnt_r == '0) r.status = ST_NO_FREE;
      else if (mode_r > 2'd1) r.status = ST_BAD_MODE;
      else if (mode_r == 2'd0 && dly_r == '0) r.status = ST_BAD_DLY;
      else if (mode_r == 2'd1 && per_r == '0) r.status = ST_BAD_PER;
      else begin
        do_create = 1'b1;
        r.slot_id = 4'(new_slot);
        r.slot_state = SS_STOPPED;
      end
    end else if (op_r > OP_QUERY) begin
      r.status = ST_BAD_MODE;
    end else if (!id_ok) begin
      r.status = ST_BAD_ID;
    end else begin
      r.slot_id = 4'(sid);
      if (op_r == OP_DELETE) begin
        do_release = (stat_r[sid] != SS_UNUSED);
      end else if (stat_r[sid] == SS_UNUSED) begin
        r.status = ST_INACTIVE;
      end else if (op_r == OP_START) begin
        do_start = 1'b1;
        r.slot_state = SS_RUNNING;
      end else if (op_r == OP_STOP) begin
        r.slot_state = SS_STOPPED;
        if (stat_r[sid] == SS_STOPPED) r.status = ST_STOPPED_ALREADY;
        else begin
          do_stop = 1'b1;
          if (!hcb_r[sid]) r.status = ST_NO_CB;
          else if (opt_r == 2'd1) begin
            r.fired = 1'b1;
            r.fire_tag = stag_r[sid];
          end else if (opt_r == 2'd2) begin
            r.fired = 1'b1;
            r.fire_tag = tag_r;
          end
        end
      end else begin
        r.slot_state = stat_r[sid];
        r.remaining_ticks = match_r[sid] - tick_r;
      end
    end
  end

  logic exec;
  assign exec = cmd.cmd || cmd.scan;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; id_r <= in_timer_id; mode_r <= in_timer_mode;
      dly_r <= in_delay_ticks; per_r <= in_period_ticks;
      cb_r <= in_has_callback; tag_r <= in_callback_tag; opt_r <= in_stop_option;
    end
    if (exec || cmd.emit_idle) res_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        stat_r[i] <= SS_UNUSED;
        fstk_r[i] <= IW'(NUM_TIMERS - 1 - i);
      end
      fcnt_r <= CW'(NUM_TIMERS);
      tick_r <= '0;
      scan_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (exec || cmd.emit_idle) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cmd.load) scan_r <= '0;
      else if (cmd.scan_next) scan_r <= scan_r + IW'(1);
      if (cmd.tick_done) tick_r <= tick_r + 32'd1;
      if (exec) begin
        if (do_create) begin
          fcnt_r <= fcnt_r - CW'(1);
          stat_r[new_slot] <= SS_STOPPED;
          peri_r[new_slot] <= mode_r[0];
          sdly_r[new_slot] <= dly_r;
          sper_r[new_slot] <= per_r;
          match_r[new_slot] <= '0;
          hcb_r[new_slot] <= cb_r;
          stag_r[new_slot] <= tag_r;
        end
        if (do_release) begin
          stat_r[rel_slot] <= SS_UNUSED;
          peri_r[rel_slot] <= 1'b0;
          sdly_r[rel_slot] <= '0;
          sper_r[rel_slot] <= '0;
          match_r[rel_slot] <= '0;
          hcb_r[rel_slot] <= 1'b0;
          stag_r[rel_slot] <= '0;
          if (32'(fcnt_r) < 32'(NUM_TIMERS)) begin
            fstk_r[IW'(fcnt_r)] <= rel_slot;
            fcnt_r <= fcnt_r + CW'(1);
          end
        end
        if (cmd.scan && peri_r[scan_r]) match_r[scan_r] <= tick_r + sper_r[scan_r];
        if (do_start) begin
          stat_r[sid] <= SS_RUNNING;
          match_r[sid] <= tick_r + sdly_r[sid];
        end
        if (do_stop) stat_r[sid] <= SS_STOPPED;
      end
    end
  end

  assign out_valid = ov_r;
  assign res = res_r;

  `ASSERT_NEVER(a_fcnt_range, clk, rst_n, 32'(fcnt_r) > 32'(NUM_TIMERS))
  `ASSERT_NEVER(a_no_overwrite, clk, rst_n, (exec || cmd.emit_idle) && ov_r && out_stall)
  `ASSERT_CLK(a_res_hold, clk, rst_n, (ov_r && out_stall) |=> (ov_r && $stable(res_r)))
endmodule

>>> sim/one_shot_periodic_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_bank_tb
// Drives commands and ticks into the timer bank, predicts every result word
// from a model of the slot pool and compares each accepted word in order.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_bank_tb;
  import otb_pkg::*;

  localparam int NT = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [1:0]  mode;
    logic [31:0] dly;
    logic [31:0] per;
    logic        cb;
    logic [15:0] tag;
    logic [1:0]  opt;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_op = '0;
  logic [7:0] in_timer_id = '0;
  logic [1:0] in_timer_mode = '0;
  logic [31:0] in_delay_ticks = '0;
  logic [31:0] in_period_ticks = '0;
  logic in_has_callback = 1'b0;
  logic [15:0] in_callback_tag = '0;
  logic [1:0] in_stop_option = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_status;
  logic [3:0] out_slot_id;
  logic [1:0] out_slot_state;
  logic [31:0] out_remaining_ticks;
  logic out_fired;
  logic [15:0] out_fire_tag;
  logic out_last;

  one_shot_periodic_timer_bank u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pool model
  logic [31:0] m_tick;
  logic [1:0]  m_state [NT];
  logic        m_per_mode [NT];
  logic [31:0] m_dly [NT];
  logic [31:0] m_per [NT];
  logic [31:0] m_match [NT];
  logic        m_cb [NT];
  logic [15:0] m_tag [NT];
  logic [3:0]  m_stack [NT];
  int          m_free;

  cmd_word_t pending_words[$];
  res_t      expected_results[$];
  int        errors = 0;
  int        send_idle = 25;
  int        recv_idle = 87;
  bit        hold_recv = 0;
  bit        hold_send = 0;
  bit        in_taken = 0;

  function automatic res_t mk(logic [3:0] st, logic [3:0] s, logic [1:0] ss,
                              logic [31:0] rem, logic f, logic [15:0] t, logic l);
    res_t r;
    r.status = st; r.slot_id = s; r.slot_state = ss; r.remaining_ticks = rem;
    r.fired = f; r.fire_tag = t; r.last = l;
    return r;
  endfunction

  task automatic pool_reset();
    m_tick = '0;
    for (int i = 0; i < NT; i++) begin
      m_state[i] = SS_UNUSED; m_per_mode[i] = 0; m_dly[i] = 0; m_per[i] = 0;
      m_match[i] = 0; m_cb[i] = 0; m_tag[i] = 0; m_stack[i] = 4'(NT - 1 - i);
    end
    m_free = NT;
  endtask

  task automatic pool_release(int s);
    m_state[s] = SS_UNUSED; m_per_mode[s] = 0; m_dly[s] = 0; m_per[s] = 0;
    m_match[s] = 0; m_cb[s] = 0; m_tag[s] = 0;
    if (m_free < NT) begin
      m_stack[m_free] = 4'(s);
      m_free++;
    end
  endtask

  task automatic predict_pool(cmd_word_t w);
    int s;
    int n;
    logic [1:0] aft;
    n = 0;
    if (w.op == OP_TICK) begin
      for (int i = 0; i < NT; i++) begin
        if (m_state[i] == SS_RUNNING && m_match[i] == m_tick) begin
          logic hc;
          logic [15:0] t;
          hc = m_cb[i];
          t = hc ? m_tag[i] : 16'd0;
          if (m_per_mode[i]) begin
            m_match[i] = m_tick + m_per[i];
            aft = SS_RUNNING;
          end else begin
            pool_release(i);
            aft = SS_UNUSED;
          end
          expected_results.push_back(mk(ST_OK, 4'(i), aft, 0, hc, t, 0));
          n++;
        end
      end
      m_tick++;
      if (n == 0) expected_results.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
      else expected_results[$].last = 1'b1;
    end else if (w.op == OP_CREATE) begin
      if (m_free == 0) expected_results.push_back(mk(ST_NO_FREE, 0, 0, 0, 0, 0, 1));
      else if (w.mode > 1) expected_results.push_back(mk(ST_BAD_MODE, 0, 0, 0, 0, 0, 1));
      else if (w.mode == 0 && w.dly == 0)
        expected_results.push_back(mk(ST_BAD_DLY, 0, 0, 0, 0, 0, 1));
      else if (w.mode == 1 && w.per == 0)
        expected_results.push_back(mk(ST_BAD_PER, 0, 0, 0, 0, 0, 1));
      else begin
        m_free--;
        s = m_stack[m_free];
        m_state[s] = SS_STOPPED; m_per_mode[s] = w.mode[0]; m_dly[s] = w.dly;
        m_per[s] = w.per; m_match[s] = 0; m_cb[s] = w.cb; m_tag[s] = w.tag;
        expected_results.push_back(mk(ST_OK, 4'(s), SS_STOPPED, 0, 0, 0, 1));
      end
    end else if (w.op > OP_QUERY) begin
      expected_results.push_back(mk(ST_BAD_MODE, 0, 0, 0, 0, 0, 1));
    end else if (w.id >= NT) begin
      expected_results.push_back(mk(ST_BAD_ID, 0, 0, 0, 0, 0, 1));
    end else begin
      s = w.id;
      if (w.op == OP_DELETE) begin
        if (m_state[s] != SS_UNUSED) pool_release(s);
        expected_results.push_back(mk(ST_OK, 4'(s), SS_UNUSED, 0, 0, 0, 1));
      end else if (m_state[s] == SS_UNUSED) begin
        expected_results.push_back(mk(ST_INACTIVE, 4'(s), SS_UNUSED, 0, 0, 0, 1));
      end else if (w.op == OP_START) begin
        m_state[s] = SS_RUNNING;
        m_match[s] = m_tick + m_dly[s];
        expected_results.push_back(mk(ST_OK, 4'(s), SS_RUNNING, 0, 0, 0, 1));
      end else if (w.op == OP_STOP) begin
        if (m_state[s] == SS_STOPPED)
          expected_results.push_back(mk(ST_STOPPED_ALREADY, 4'(s), SS_STOPPED, 0, 0, 0, 1));
        else begin
          m_state[s] = SS_STOPPED;
          if (!m_cb[s])
            expected_results.push_back(mk(ST_NO_CB, 4'(s), SS_STOPPED, 0, 0, 0, 1));
          else if (w.opt == 1)
            expected_results.push_back(mk(ST_OK, 4'(s), SS_STOPPED, 0, 1, m_tag[s], 1));
          else if (w.opt == 2)
            expected_results.push_back(mk(ST_OK, 4'(s), SS_STOPPED, 0, 1, w.tag, 1));
          else
            expected_results.push_back(mk(ST_OK, 4'(s), SS_STOPPED, 0, 0, 0, 1));
        end
      end else begin
        expected_results.push_back(mk(ST_OK, 4'(s), m_state[s], m_match[s] - m_tick,
                                      0, 0, 1));
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0h exp %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        if (pending_words.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          cmd_word_t w;
          w = pending_words.pop_front();
          in_op <= w.op; in_timer_id <= w.id; in_timer_mode <= w.mode;
          in_delay_ticks <= w.dly; in_period_ticks <= w.per;
          in_has_callback <= w.cb; in_callback_tag <= w.tag; in_stop_option <= w.opt;
        end else in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (pending_words.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          cmd_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_op <= w.op; in_timer_id <= w.id; in_timer_mode <= w.mode;
          in_delay_ticks <= w.dly; in_period_ticks <= w.per;
          in_has_callback <= w.cb; in_callback_tag <= w.tag; in_stop_option <= w.opt;
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        cmd_word_t w;
        w = {in_op, in_timer_id, in_timer_mode, in_delay_ticks, in_period_ticks,
             in_has_callback, in_callback_tag, in_stop_option};
        predict_pool(w);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_status, 0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_slot_id != e.slot_id) report_mismatch("slot_id", out_slot_id, e.slot_id);
          if (out_slot_state != e.slot_state)
            report_mismatch("slot_state", out_slot_state, e.slot_state);
          if (out_remaining_ticks != e.remaining_ticks)
            report_mismatch("remaining", out_remaining_ticks, e.remaining_ticks);
          if (out_fired != e.fired) report_mismatch("fired", out_fired, e.fired);
          if (out_fire_tag != e.fire_tag) report_mismatch("fire_tag", out_fire_tag, e.fire_tag);
          if (out_last != e.last) report_mismatch("last", out_last, e.last);
        end
      end
    end
  end

  function automatic cmd_word_t cw(logic [2:0] op, logic [7:0] id, logic [1:0] mode,
                                   logic [31:0] dly, logic [31:0] per, logic cb,
                                   logic [15:0] tag, logic [1:0] opt);
    cmd_word_t w;
    w = {op, id, mode, dly, per, cb, tag, opt};
    return w;
  endfunction

  function automatic cmd_word_t rand_word(bit noise);
    cmd_word_t w;
    int r;
    w = {$urandom, $urandom, $urandom};
    r = $urandom_range(99);
    if (noise) return w;
    w.id = (r < 90) ? 8'($urandom_range(NT - 1)) : w.id;
    w.mode = ($urandom_range(9) == 0) ? w.mode : 2'($urandom_range(1));
    w.dly = ($urandom_range(9) == 0) ? w.dly : 32'($urandom_range(5));
    w.per = ($urandom_range(9) == 0) ? w.per : 32'($urandom_range(4));
    r = $urandom_range(99);
    if (r < 40) w.op = OP_TICK;
    else if (r < 55) w.op = OP_CREATE;
    else if (r < 72) w.op = OP_START;
    else if (r < 82) w.op = OP_STOP;
    else if (r < 90) w.op = OP_DELETE;
    else w.op = OP_QUERY;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    pool_reset();
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    // directed
    pending_words.push_back(cw(OP_START, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_QUERY, 8'hff, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_CREATE, 0, 2'd3, 1, 1, 1, 0, 0));
    pending_words.push_back(cw(OP_CREATE, 0, 0, 0, 1, 1, 0, 0));
    pending_words.push_back(cw(OP_CREATE, 0, 1, 0, 0, 1, 0, 0));
    pending_words.push_back(cw(OP_CREATE, 0, 1, 0, 2, 1, 16'hffff, 0));
    pending_words.push_back(cw(OP_CREATE, 0, 0, 32'hffffffff, 32'hffffffff, 0, 0, 3));
    pending_words.push_back(cw(OP_CREATE, 0, 0, 1, 0, 1, 16'h1234, 0));
    pending_words.push_back(cw(OP_START, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_START, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_START, 2, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_QUERY, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(3'd6, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(3'd7, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_STOP, 0, 0, 0, 0, 0, 16'hbeef, 2));
    pending_words.push_back(cw(OP_START, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_STOP, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_START, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_STOP, 0, 0, 0, 0, 0, 0, 1));
    pending_words.push_back(cw(OP_DELETE, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_DELETE, 9, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 18; i++) pending_words.push_back(cw(OP_CREATE, 0, 1, 0, 1, 1, 16'(i), 0));
    wait_drained();
    // random, first idling pattern, with a long receiver hold-off
    for (int i = 0; i < 110; i++) pending_words.push_back(rand_word($urandom_range(9) == 0));
    hold_recv = 1;
    repeat (400) @(posedge clk);
    hold_recv = 0;
    wait_drained();
    send_idle = 87; recv_idle = 25;
    // all slots periodic and running, then a full tick
    for (int i = 0; i < NT; i++) pending_words.push_back(cw(OP_DELETE, 8'(i), 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < NT; i++) pending_words.push_back(cw(OP_CREATE, 0, 1, 0, 1, 1, 16'(i), 0));
    for (int i = 0; i < NT; i++) pending_words.push_back(cw(OP_START, 8'(i), 0, 0, 0, 0, 0, 0));
    pending_words.push_back(cw(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 60; i++) pending_words.push_back(rand_word($urandom_range(9) == 0));
    repeat (150) @(posedge clk);
    hold_send = 1;
    while (expected_results.size() > 0 || in_valid) @(posedge clk);
    hold_send = 0;
    wait_drained();
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 70; i++) pending_words.push_back(rand_word($urandom_range(9) == 0));
    wait_drained();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
